[hdl/lad_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lad_pkg
// Types and constants shared by the linear array deque.
// ----------------------------------------------------------------------------
package lad_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_FRONT = 2'd2,
    ST_NO_REAR  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] pop_value;
    logic [1:0]              status;
    logic                    is_full;
    logic                    is_empty;
  } out_item_t;

endpackage
`default_nettype wire

[hdl/linear_array_deque_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// linear_array_deque_top
// A non-circular array deque whose elements live in one synchronous memory.
//
// Each input item is a request: push front, push rear, pop front or pop rear.
// Every request yields exactly one result item with the popped value, a
// status and the full and empty flags as they stand after the request.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. A request is decided and its memory access issued in the
// cycle it is accepted, so one request per cycle is sustained while the
// receiver does not stall. The memory read is captured in the read stage
// at acceptance and then moves into the output register. When the
// receiver stalls, the result waits in the output register, one more
// request is held in the read stage, and then the input is stalled.
// Reset empties the deque at once; slot contents are not cleared and are
// never returned before they are written.
// ----------------------------------------------------------------------------
module linear_array_deque_top
  import lad_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata_r;

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_pop_r, s1_pop_nxt;
  status_t          s1_status_r, s1_status_nxt;
  logic             s1_full_r, s1_full_nxt;
  logic             s1_empty_r, s1_empty_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             in_acc;
  logic             s1_move;
  logic [CNT_W-1:0] end_idx;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  req_t             req;

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;
  assign req      = req_t'(in_item.req_type);
  assign end_idx  = CNT_W'(front_r) + fill_r;

  always_comb begin
    front_nxt     = front_r;
    fill_nxt      = fill_r;
    s1_status_nxt = ST_OK;
    s1_pop_nxt    = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    wr_addr       = front_r;
    rd_addr       = front_r;
    case (req)
      REQ_PUSH_FRONT: begin
        if (front_r == '0) begin
          s1_status_nxt = ST_NO_FRONT;
        end else begin
          front_nxt = front_r - 1'b1;
          wr_addr   = front_r - 1'b1;
          wr_en     = 1'b1;
          fill_nxt  = fill_r + 1'b1;
        end
      end
      REQ_PUSH_REAR: begin
        if (end_idx >= DEPTH_C) begin
          s1_status_nxt = ST_NO_REAR;
        end else begin
          wr_addr  = end_idx[IDX_W-1:0];
          wr_en    = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      REQ_POP_FRONT, REQ_POP_REAR: begin
        if (fill_r == '0) begin
          s1_status_nxt = ST_EMPTY;
        end else begin
          s1_pop_nxt = 1'b1;
          rd_en      = 1'b1;
          if (req == REQ_POP_FRONT) begin
            rd_addr   = front_r;
            front_nxt = front_r + 1'b1;
          end else begin
            rd_addr = IDX_W'(end_idx - 1'b1);
          end
          fill_nxt = fill_r - 1'b1;
          if (fill_nxt == '0) begin
            front_nxt = '0;
          end
        end
      end
      default: begin
        s1_status_nxt = ST_OK;
      end
    endcase
    s1_full_nxt  = (front_nxt == '0) && (fill_nxt == DEPTH_C);
    s1_empty_nxt = (fill_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      mem[wr_addr] <= in_item.push_value;
    end
    if (in_acc && rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_move) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.pop_value = s1_pop_r ? rdata_r : '0;
      out_item_nxt.status    = s1_status_r;
      out_item_nxt.is_full   = s1_full_r;
      out_item_nxt.is_empty  = s1_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        front_r <= front_nxt;
        fill_r  <= fill_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pop_r    <= s1_pop_nxt;
      s1_status_r <= s1_status_nxt;
      s1_full_r   <= s1_full_nxt;
      s1_empty_r  <= s1_empty_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("fill count exceeds depth");

  a_empty_front : assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (front_r == '0))
    else $error("empty deque with nonzero front index");

  a_flags_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.is_full && out_item_r.is_empty))
    else $error("result reports full and empty together");

  a_empty_status : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status == ST_EMPTY) |->
      (out_item_r.is_empty && out_item_r.pop_value == '0))
    else $error("empty pop result is inconsistent");

endmodule
`default_nettype wire
